>>> rtl/mm4_pkg.sv
package mm4_pkg;

	localparam int DATA_WIDTH = 32;
	localparam int FRAC_BITS  = DATA_WIDTH / 2;
	localparam int PROD_WIDTH = 2 * DATA_WIDTH;
	localparam int ACC_GUARD  = 2;
	localparam int ACC_WIDTH  = PROD_WIDTH + ACC_GUARD;
	localparam int IDX_WIDTH  = 4;
	localparam int MAT_DEPTH  = 16;
	localparam int STEP_WIDTH = 3;

	localparam logic [IDX_WIDTH-1:0] LAST_INDEX = IDX_WIDTH'(MAT_DEPTH - 1);

	localparam logic [STEP_WIDTH-1:0] STEP_IDLE  = STEP_WIDTH'(0);
	localparam logic [STEP_WIDTH-1:0] STEP_FIRST = STEP_WIDTH'(1);

	typedef enum logic [1:0] {
		JMP_NEXT,
		JMP_WAIT_GO,
		JMP_FIN
	} jmp_t;

	typedef struct packed {
		logic       rd_en;
		logic [1:0] rd_k;
		logic       mul_en;
		logic       acc_en;
		logic       acc_first;
		logic       fin;
		jmp_t       jmp;
	} ctrl_t;

	typedef struct packed {
		logic out_free;
		logic last_elem;
	} status_t;

	// One element: four reads, four multiplies, four accumulates, then write out.
	function automatic ctrl_t ucode(input logic [STEP_WIDTH-1:0] step);
		ctrl_t c;
		c = '{rd_en: 1'b0, rd_k: 2'd0, mul_en: 1'b0, acc_en: 1'b0,
		      acc_first: 1'b0, fin: 1'b0, jmp: JMP_NEXT};
		case (step)
			3'd0: c.jmp = JMP_WAIT_GO;
			3'd1: begin
				c.rd_en = 1'b1; c.rd_k = 2'd0;
			end
			3'd2: begin
				c.rd_en = 1'b1; c.rd_k = 2'd1; c.mul_en = 1'b1;
			end
			3'd3: begin
				c.rd_en = 1'b1; c.rd_k = 2'd2; c.mul_en = 1'b1;
				c.acc_en = 1'b1; c.acc_first = 1'b1;
			end
			3'd4: begin
				c.rd_en = 1'b1; c.rd_k = 2'd3; c.mul_en = 1'b1; c.acc_en = 1'b1;
			end
			3'd5: begin
				c.mul_en = 1'b1; c.acc_en = 1'b1;
			end
			3'd6: c.acc_en = 1'b1;
			3'd7: begin
				c.fin = 1'b1; c.jmp = JMP_FIN;
			end
			default: c.jmp = JMP_WAIT_GO;
		endcase
		return c;
	endfunction

endpackage

>>> rtl/mm4_ram.sv
module mm4_ram #(
	parameter int Width = 32,
	parameter int Depth = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(Depth)-1:0] wr_addr,
	input  logic [Width-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(Depth)-1:0] rd_addr,
	output logic [Width-1:0]         rd_data
);

	logic [Width-1:0] mem_q [Depth];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

>>> rtl/mm4_seq.sv
module mm4_seq (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             go,
	input  mm4_pkg::status_t status,
	output mm4_pkg::ctrl_t   ctrl,
	output logic             busy
);

	logic [mm4_pkg::STEP_WIDTH-1:0] step_q;
	logic [mm4_pkg::STEP_WIDTH-1:0] step_next;

	assign ctrl = mm4_pkg::ucode(step_q);
	assign busy = (step_q != mm4_pkg::STEP_IDLE);

	always_comb begin
		step_next = step_q + mm4_pkg::STEP_WIDTH'(1);
		case (ctrl.jmp)
			mm4_pkg::JMP_NEXT: step_next = step_q + mm4_pkg::STEP_WIDTH'(1);
			mm4_pkg::JMP_WAIT_GO:
				step_next = go ? mm4_pkg::STEP_FIRST : mm4_pkg::STEP_IDLE;
			mm4_pkg::JMP_FIN: begin
				// hold until the output register can take the element
				if (!status.out_free) begin
					step_next = step_q;
				end else if (status.last_elem) begin
					step_next = mm4_pkg::STEP_IDLE;
				end else begin
					step_next = mm4_pkg::STEP_FIRST;
				end
			end
			default: step_next = mm4_pkg::STEP_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= mm4_pkg::STEP_IDLE;
		end else begin
			step_q <= step_next;
		end
	end

endmodule

>>> rtl/mm4_dp.sv
module mm4_dp (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  wr_en,
	input  logic [mm4_pkg::IDX_WIDTH-1:0]         wr_index,
	input  logic signed [mm4_pkg::DATA_WIDTH-1:0] wr_left,
	input  logic signed [mm4_pkg::DATA_WIDTH-1:0] wr_right,
	input  mm4_pkg::ctrl_t                        ctrl,
	output mm4_pkg::status_t                      status,
	input  logic                                  out_stall,
	output logic                                  out_valid,
	output logic [mm4_pkg::IDX_WIDTH-1:0]         result_index,
	output logic signed [mm4_pkg::DATA_WIDTH-1:0] product_value,
	output logic                                  saturated,
	output logic                                  last_result
);

	localparam int DW = mm4_pkg::DATA_WIDTH;
	localparam int AW = mm4_pkg::ACC_WIDTH;
	localparam int SW = AW - mm4_pkg::FRAC_BITS;

	logic [mm4_pkg::IDX_WIDTH-1:0] elem_q;
	logic [mm4_pkg::IDX_WIDTH-1:0] left_addr;
	logic [mm4_pkg::IDX_WIDTH-1:0] right_addr;
	logic [DW-1:0]                 left_rd;
	logic [DW-1:0]                 right_rd;
	logic signed [mm4_pkg::PROD_WIDTH-1:0] prod_q;
	logic signed [AW-1:0]          acc_q;
	logic signed [AW-1:0]          prod_ext;
	logic signed [SW-1:0]          shifted;
	logic [SW-DW:0]                upper;
	logic                          fits;
	logic                          fire;
	logic                          out_valid_q;

	// column-major: left[k*4+row], right[col*4+k], element = col*4+row
	assign left_addr  = {ctrl.rd_k, elem_q[1:0]};
	assign right_addr = {elem_q[3:2], ctrl.rd_k};

	mm4_ram #(.Width(DW), .Depth(mm4_pkg::MAT_DEPTH)) u_left_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_index),
		.wr_data (wr_left),
		.rd_en   (ctrl.rd_en),
		.rd_addr (left_addr),
		.rd_data (left_rd)
	);

	mm4_ram #(.Width(DW), .Depth(mm4_pkg::MAT_DEPTH)) u_right_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_index),
		.wr_data (wr_right),
		.rd_en   (ctrl.rd_en),
		.rd_addr (right_addr),
		.rd_data (right_rd)
	);

	assign prod_ext = {{mm4_pkg::ACC_GUARD{prod_q[mm4_pkg::PROD_WIDTH-1]}}, prod_q};

	always_ff @(posedge clk) begin
		if (ctrl.mul_en) begin
			prod_q <= $signed(left_rd) * $signed(right_rd);
		end
		if (ctrl.acc_en) begin
			acc_q <= ctrl.acc_first ? prod_ext : acc_q + prod_ext;
		end
	end

	assign shifted = SW'(acc_q >>> mm4_pkg::FRAC_BITS);
	assign upper   = shifted[SW-1:DW-1];
	assign fits    = (&upper) || !(|upper);

	assign status.out_free  = !out_valid_q || !out_stall;
	assign status.last_elem = (elem_q == mm4_pkg::LAST_INDEX);
	assign fire             = ctrl.fin && status.out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			elem_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (fire) begin
				elem_q      <= elem_q + mm4_pkg::IDX_WIDTH'(1);
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			result_index <= elem_q;
			last_result  <= status.last_elem;
			saturated    <= !fits;
			if (fits) begin
				product_value <= shifted[DW-1:0];
			end else if (acc_q[AW-1]) begin
				product_value <= {1'b1, {(DW-1){1'b0}}};
			end else begin
				product_value <= {1'b0, {(DW-1){1'b1}}};
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

>>> rtl/matrix4_multiply.sv
// Loads one element pair per cycle while idle; the request with index 15 starts the product.
// The 16 results then follow one per pass of the 7-step microprogram through the shared
// multiplier; a pass holds at its last step while the output register is full and stalled.
// Input stall stays high until the last result. Reset clears the step counter,
// element counter and output valid; matrix RAM contents are undefined until written.
module matrix4_multiply (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic [mm4_pkg::IDX_WIDTH-1:0]         element_index,
	input  logic signed [mm4_pkg::DATA_WIDTH-1:0] left_value,
	input  logic signed [mm4_pkg::DATA_WIDTH-1:0] right_value,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic [mm4_pkg::IDX_WIDTH-1:0]         result_index,
	output logic signed [mm4_pkg::DATA_WIDTH-1:0] product_value,
	output logic                                  saturated,
	output logic                                  last_result
);

	mm4_pkg::ctrl_t   ctrl;
	mm4_pkg::status_t status;
	logic             busy;
	logic             accept;
	logic             go;

	assign in_stall = busy;
	assign accept   = in_valid && !busy;
	assign go       = accept && (element_index == mm4_pkg::LAST_INDEX);

	mm4_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (go),
		.status (status),
		.ctrl   (ctrl),
		.busy   (busy)
	);

	mm4_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.wr_en         (accept),
		.wr_index      (element_index),
		.wr_left       (left_value),
		.wr_right      (right_value),
		.ctrl          (ctrl),
		.status        (status),
		.out_stall     (out_stall),
		.out_valid     (out_valid),
		.result_index  (result_index),
		.product_value (product_value),
		.saturated     (saturated),
		.last_result   (last_result)
	);

endmodule
